FILE: hw/rtl/etcf_pkg.sv
`default_nettype none

package etcf_pkg;

    localparam int QUEUE_DEPTH = 2048;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int ENTRY_W     = 49;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_CAPTURE = 2'd1;
    localparam logic [1:0] KIND_POP     = 2'd2;

    localparam logic [IDX_W-1:0] INDEX_RESET = IDX_W'(1);

    typedef struct packed {
        logic tick;       // count one timer wrap
        logic capture;    // overruns, falling edge, latch rising edge
        logic rise;       // handle latched rising edge
        logic pop_empty;  // load empty result
        logic pop_read;   // issue store read at read index
        logic pop_load;   // load popped entry into output register
    } etcf_cmd_t;

    typedef struct packed {
        logic empty;
    } etcf_status_t;

    // Ring index advance, wrapping at QUEUE_DEPTH
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                  input logic [1:0] step);
        logic [IDX_W:0] sum;
        sum = {1'b0, i} + (IDX_W+1)'(step);
        if (sum >= (IDX_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/etcf_ctrl.sv
`default_nettype none

module etcf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [1:0]            in_kind,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire etcf_pkg::etcf_status_t status,
    output etcf_pkg::etcf_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RISE = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // Hold all requests while busy, and a pop while the last result is untaken
    assign in_stall  = (state_reg != ST_IDLE) ||
                       (out_valid_reg && (in_kind == etcf_pkg::KIND_POP));
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.tick      = accept && (in_kind == etcf_pkg::KIND_TICK);
        cmd.capture   = accept && (in_kind == etcf_pkg::KIND_CAPTURE);
        cmd.pop_empty = accept && (in_kind == etcf_pkg::KIND_POP) && status.empty;
        cmd.pop_read  = accept && (in_kind == etcf_pkg::KIND_POP) && !status.empty;
        cmd.rise      = (state_reg == ST_RISE);
        cmd.pop_load  = (state_reg == ST_READ);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_RISE;
                end
                else if (cmd.pop_read)
                begin
                    state_next = ST_READ;
                end
            end
            ST_RISE: state_next = ST_IDLE;
            ST_READ: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.pop_empty || cmd.pop_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> out_valid_reg)
        else $error("store read did not produce a result");

    a_rise_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RISE) |=> (state_reg == ST_IDLE))
        else $error("rising edge step did not return to idle");

    a_pop_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_read |=> (state_reg == ST_READ))
        else $error("nonempty pop did not enter read");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/etcf_datapath.sv
`default_nettype none

module etcf_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire etcf_pkg::etcf_cmd_t    cmd,
    output etcf_pkg::etcf_status_t      status,
    input  wire logic                   falling_edge,
    input  wire logic                   rising_edge,
    input  wire logic [15:0]            falling_time,
    input  wire logic [15:0]            rising_time,
    input  wire logic                   falling_overrun,
    input  wire logic                   rising_overrun,
    output logic                        entry_valid,
    output logic                        is_rising,
    output logic [31:0]                 wrap_stamp,
    output logic [15:0]                 capture_time,
    output logic [31:0]                 interval,
    output logic [31:0]                 drop_count,
    output logic [7:0]                  slot_low
);

    localparam int IW = etcf_pkg::IDX_W;
    localparam int EW = etcf_pkg::ENTRY_W;

    logic [EW-1:0] capture_store_reg [etcf_pkg::QUEUE_DEPTH];
    logic [EW-1:0] rd_data_reg;

    logic [IW-1:0] read_index_reg,  read_index_next;
    logic [IW-1:0] write_index_reg, write_index_next;
    logic [31:0]   wrap_count_reg,  wrap_count_next;
    logic [31:0]   drop_total_reg,  drop_total_next;
    logic [31:0]   last_low_reg,    last_low_next;
    logic          rise_pend_reg,   rise_pend_next;
    logic [15:0]   rise_time_reg,   rise_time_next;

    logic          entry_valid_reg,  entry_valid_next;
    logic          is_rising_reg,    is_rising_next;
    logic [31:0]   wrap_stamp_reg,   wrap_stamp_next;
    logic [15:0]   capture_time_reg, capture_time_next;
    logic [31:0]   interval_reg,     interval_next;
    logic [31:0]   drop_count_reg,   drop_count_next;
    logic [7:0]    slot_low_reg,     slot_low_next;

    logic          near_full;
    logic [1:0]    drop_inc;
    logic          mem_we;
    logic [EW-1:0] mem_wdata;
    logic [31:0]   popped_low;

    assign status.empty = (read_index_reg == write_index_reg);

    // Fewer than two free slots: drop the edge
    assign near_full = (etcf_pkg::next_idx(write_index_reg, 2'd1) == read_index_reg) ||
                       (etcf_pkg::next_idx(write_index_reg, 2'd2) == read_index_reg);

    assign popped_low = rd_data_reg[31:0];

    always_comb
    begin
        read_index_next   = read_index_reg;
        write_index_next  = write_index_reg;
        wrap_count_next   = wrap_count_reg;
        drop_total_next   = drop_total_reg;
        last_low_next     = last_low_reg;
        rise_pend_next    = rise_pend_reg;
        rise_time_next    = rise_time_reg;
        entry_valid_next  = entry_valid_reg;
        is_rising_next    = is_rising_reg;
        wrap_stamp_next   = wrap_stamp_reg;
        capture_time_next = capture_time_reg;
        interval_next     = interval_reg;
        drop_count_next   = drop_count_reg;
        slot_low_next     = slot_low_reg;
        drop_inc          = 2'd0;
        mem_we            = 1'b0;
        mem_wdata         = {1'b0, wrap_count_reg, falling_time};

        if (cmd.tick)
        begin
            wrap_count_next = wrap_count_reg + 32'd1;
        end

        if (cmd.capture)
        begin
            drop_inc = {1'b0, falling_overrun} + {1'b0, rising_overrun};
            if (falling_edge)
            begin
                if (near_full)
                begin
                    drop_inc = drop_inc + 2'd1;
                end
                else
                begin
                    mem_we           = 1'b1;
                    mem_wdata        = {1'b0, wrap_count_reg, falling_time};
                    write_index_next = etcf_pkg::next_idx(write_index_reg, 2'd1);
                end
            end
            drop_total_next = drop_total_reg + 32'(drop_inc);
            rise_pend_next  = rising_edge;
            rise_time_next  = rising_time;
        end

        if (cmd.rise && rise_pend_reg)
        begin
            if (near_full)
            begin
                drop_total_next = drop_total_reg + 32'd1;
            end
            else
            begin
                mem_we           = 1'b1;
                mem_wdata        = {1'b1, wrap_count_reg, rise_time_reg};
                write_index_next = etcf_pkg::next_idx(write_index_reg, 2'd1);
            end
        end

        if (cmd.pop_empty)
        begin
            entry_valid_next  = 1'b0;
            is_rising_next    = 1'b0;
            wrap_stamp_next   = 32'd0;
            capture_time_next = 16'd0;
            interval_next     = 32'd0;
            drop_count_next   = drop_total_reg;
            slot_low_next     = 8'd0;
        end

        if (cmd.pop_load)
        begin
            entry_valid_next  = 1'b1;
            is_rising_next    = rd_data_reg[48];
            wrap_stamp_next   = rd_data_reg[47:16];
            capture_time_next = rd_data_reg[15:0];
            interval_next     = popped_low - last_low_reg;
            drop_count_next   = drop_total_reg;
            slot_low_next     = 8'(read_index_reg);
            last_low_next     = popped_low;
            read_index_next   = etcf_pkg::next_idx(read_index_reg, 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            capture_store_reg[write_index_reg] <= mem_wdata;
        end
        if (cmd.pop_read)
        begin
            rd_data_reg <= capture_store_reg[read_index_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_index_reg  <= etcf_pkg::INDEX_RESET;
            write_index_reg <= etcf_pkg::INDEX_RESET;
            wrap_count_reg  <= 32'd0;
            drop_total_reg  <= 32'd0;
            last_low_reg    <= 32'd0;
            rise_pend_reg   <= 1'b0;
        end
        else
        begin
            read_index_reg  <= read_index_next;
            write_index_reg <= write_index_next;
            wrap_count_reg  <= wrap_count_next;
            drop_total_reg  <= drop_total_next;
            last_low_reg    <= last_low_next;
            rise_pend_reg   <= rise_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rise_time_reg    <= rise_time_next;
        entry_valid_reg  <= entry_valid_next;
        is_rising_reg    <= is_rising_next;
        wrap_stamp_reg   <= wrap_stamp_next;
        capture_time_reg <= capture_time_next;
        interval_reg     <= interval_next;
        drop_count_reg   <= drop_count_next;
        slot_low_reg     <= slot_low_next;
    end

    assign entry_valid  = entry_valid_reg;
    assign is_rising    = is_rising_reg;
    assign wrap_stamp   = wrap_stamp_reg;
    assign capture_time = capture_time_reg;
    assign interval     = interval_reg;
    assign drop_count   = drop_count_reg;
    assign slot_low     = slot_low_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/edge_timestamp_capture_fifo.sv
// Tick: wrap count advances at accept. Capture: falling edge written at accept,
// rising edge in the next cycle through the single store write port.
// Pop: result registered the cycle after accept if empty, else loaded from
// the store read register; a pop waits while the previous result is untaken.
// Reset (rst_n, async, active low) clears indices to 1 and all counters to 0;
// the store itself is not cleared and needs no clearing pass.
`default_nettype none

module edge_timestamp_capture_fifo (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic        falling_edge,
    input  wire logic        rising_edge,
    input  wire logic [15:0] falling_time,
    input  wire logic [15:0] rising_time,
    input  wire logic        falling_overrun,
    input  wire logic        rising_overrun,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             entry_valid,
    output logic             is_rising,
    output logic [31:0]      wrap_stamp,
    output logic [15:0]      capture_time,
    output logic [31:0]      interval,
    output logic [31:0]      drop_count,
    output logic [7:0]       slot_low
);

    etcf_pkg::etcf_cmd_t    cmd;
    etcf_pkg::etcf_status_t status;

    etcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_kind   (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    etcf_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .falling_edge    (falling_edge),
        .rising_edge     (rising_edge),
        .falling_time    (falling_time),
        .rising_time     (rising_time),
        .falling_overrun (falling_overrun),
        .rising_overrun  (rising_overrun),
        .entry_valid     (entry_valid),
        .is_rising       (is_rising),
        .wrap_stamp      (wrap_stamp),
        .capture_time    (capture_time),
        .interval        (interval),
        .drop_count      (drop_count),
        .slot_low        (slot_low)
    );

endmodule

`default_nettype wire
